### hw/rtl/fpa_pkg.sv
// Shared constants and types for the first-fit page allocator.
package fpa_pkg;

   localparam int DEF_MAX_BLOCKS      = 64;
   localparam int DEF_PAGE_INDEX_BITS = 20;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_ADD    = 2'd2,
      CMD_IGNORE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_FULL     = 2'd2,
      ST_ZERO     = 2'd3
   } status_type;

endpackage

### hw/rtl/fpa_ram.sv
// Generic simple dual-port RAM with registered read.
module fpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hw/rtl/first_fit_page_allocator.sv
// First-fit page allocator: sorted free-block table in RAM, scan sequencer.
//
// Usage: drive req_command, req_base_page and req_page_count and raise start
// while busy is low; that beat is taken at the clock edge. busy then stays
// high until the result is out. Commands: allocate (first block long enough,
// remainder kept), free and add-region (inserted in address order, merged
// with exactly adjacent neighbours).
// Each request gives one result beat: rsp_valid is high for one cycle with
// rsp_status, rsp_start_page and rsp_free_total. The receiver cannot stall.
// Sequencing: trivial cases (zero count, unknown command, and for an allocate
// a request above the free total or an empty table) go from IDLE straight to
// DONE, which registers the strobe. Otherwise the table is scanned one entry
// per cycle through the RAM read port up to the hit or the insert point, then
// an insert or removal shifts the tail one entry per cycle (one read and one
// write per cycle). Worst case is a free inserted inside the table: the scan
// runs to the insert point and then the whole tail is shifted up by one entry.
// Throughput: one request at a time; start is taken again once busy drops,
// the cycle in which rsp_valid is shown.
// Reset: clears the state, strobe, block count and free total; the RAM is not
// cleared, since only entries below the count are ever used.
module first_fit_page_allocator
   import fpa_pkg::*;
#(
   parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
   parameter int PAGE_INDEX_BITS = DEF_PAGE_INDEX_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [PAGE_INDEX_BITS-1:0] req_base_page,
   input  logic [PAGE_INDEX_BITS:0]   req_page_count,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [PAGE_INDEX_BITS-1:0] rsp_start_page,
   output logic [PAGE_INDEX_BITS:0]   rsp_free_total
);

   localparam int PW = PAGE_INDEX_BITS;
   localparam int LW = PAGE_INDEX_BITS + 1;
   localparam int EW = PW + LW;
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [LW-1:0] SPACE = {1'b1, {PW{1'b0}}};
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BLOCKS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SHDN   = 7'b0001000,
      S_SHUP   = 7'b0010000,
      S_INS    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   status_type      status_ff, status_in;
   logic [PW-1:0]   base_ff, base_in;
   logic [LW-1:0]   n_ff, n_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [EW-1:0]   prev_ff, prev_in;
   logic [EW-1:0]   cur_ff, cur_in;
   logic            hasprev_ff, hasprev_in;
   logic            hascur_ff, hascur_in;
   logic            inc_ff, inc_in;
   logic            dec_ff, dec_in;
   logic            fsub_ff, fsub_in;
   logic            fadd_ff, fadd_in;
   logic [PW-1:0]   page_ff, page_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [LW-1:0]   free_ff, free_in;
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [PW-1:0]   rsp_page_ff, rsp_page_in;
   logic [LW-1:0]   rsp_free_ff, rsp_free_in;

   logic            wr_en;
   logic [IW-1:0]   wr_addr, rd_addr;
   logic [EW-1:0]   wr_data, rd_data;

   // entry fields
   logic [PW-1:0]   rd_start, prev_start, cur_start;
   logic [LW-1:0]   rd_len, prev_len, cur_len;
   logic [LW-1:0]   avail, req_n_clamped;
   logic [LW-1:0]   prev_end, new_end;
   logic            merge_lo, merge_hi;
   logic [CW-1:0]   scan_nx, pos_nx, pos_pv, j_nx, j_pv, cnt_pv;
   logic [LW:0]     free_sum;

   assign rd_start   = rd_data[EW-1:LW];
   assign rd_len     = rd_data[LW-1:0];
   assign prev_start = prev_ff[EW-1:LW];
   assign prev_len   = prev_ff[LW-1:0];
   assign cur_start  = cur_ff[EW-1:LW];
   assign cur_len    = cur_ff[LW-1:0];

   // a freed block is cut to end at the top of the page space
   assign avail         = SPACE - {1'b0, req_base_page};
   assign req_n_clamped = (req_page_count > avail) ? avail : req_page_count;

   assign prev_end = {1'b0, prev_start} + prev_len;
   assign new_end  = {1'b0, base_ff} + n_ff;
   assign merge_lo = hasprev_ff && (prev_end == {1'b0, base_ff});
   assign merge_hi = hascur_ff && ({1'b0, cur_start} == new_end);

   assign scan_nx = scan_ff + 1'b1;
   assign pos_nx  = pos_ff + 1'b1;
   assign pos_pv  = pos_ff - 1'b1;
   assign j_nx    = j_ff + 1'b1;
   assign j_pv    = j_ff - 1'b1;
   assign cnt_pv  = count_ff - 1'b1;
   assign free_sum = {1'b0, free_ff} + {1'b0, n_ff};

   fpa_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      status_in     = status_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      hasprev_in    = hasprev_ff;
      hascur_in     = hascur_ff;
      inc_in        = inc_ff;
      dec_in        = dec_ff;
      fsub_in       = fsub_ff;
      fadd_in       = fadd_ff;
      page_in       = page_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_free_in   = rsp_free_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = cmd_type'(req_command);
               base_in    = req_base_page;
               n_in       = (req_command == CMD_ALLOC) ? req_page_count : req_n_clamped;
               scan_in    = '0;
               pos_in     = '0;
               hasprev_in = 1'b0;
               hascur_in  = 1'b0;
               inc_in     = 1'b0;
               dec_in     = 1'b0;
               fsub_in    = 1'b0;
               fadd_in    = 1'b0;
               page_in    = '0;
               status_in  = ST_OK;
               state_in   = S_DONE;
               unique case (req_command)
                  CMD_ALLOC: begin
                     if (req_page_count == '0) begin
                        status_in = ST_ZERO;
                     end else if (req_page_count > free_ff || count_ff == '0) begin
                        status_in = ST_NO_SPACE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FREE, CMD_ADD: begin
                     if (req_page_count == '0) begin
                        status_in = ST_ZERO;
                     end else if (count_ff == '0) begin
                        state_in = S_DECIDE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // rd_data holds entry scan_ff; fetch the next one ahead
            rd_addr = scan_nx[IW-1:0];
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_len >= n_ff) begin
                  page_in = rd_start;
                  fsub_in = 1'b1;
                  if (rd_len > n_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = scan_ff[IW-1:0];
                     wr_data  = {rd_start + n_ff[PW-1:0], rd_len - n_ff};
                     state_in = S_DONE;
                  end else begin
                     dec_in = 1'b1;
                     if (scan_nx < count_ff) begin
                        j_in     = scan_nx;
                        state_in = S_SHDN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end else if (scan_nx == count_ff) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_DONE;
               end else begin
                  scan_in = scan_nx;
               end
            end else begin
               if (rd_start > base_ff) begin
                  pos_in    = scan_ff;
                  cur_in    = rd_data;
                  hascur_in = 1'b1;
                  state_in  = S_DECIDE;
               end else begin
                  prev_in    = rd_data;
                  hasprev_in = 1'b1;
                  if (scan_nx == count_ff) begin
                     pos_in   = count_ff;
                     state_in = S_DECIDE;
                  end else begin
                     scan_in = scan_nx;
                  end
               end
            end
         end

         S_DECIDE: begin
            if (merge_lo && merge_hi) begin
               wr_en   = 1'b1;
               wr_addr = pos_pv[IW-1:0];
               wr_data = {prev_start, prev_len + n_ff + cur_len};
               rd_addr = pos_nx[IW-1:0];
               fadd_in = 1'b1;
               dec_in  = 1'b1;
               if (pos_nx < count_ff) begin
                  j_in     = pos_nx;
                  state_in = S_SHDN;
               end else begin
                  state_in = S_DONE;
               end
            end else if (merge_lo) begin
               wr_en    = 1'b1;
               wr_addr  = pos_pv[IW-1:0];
               wr_data  = {prev_start, prev_len + n_ff};
               fadd_in  = 1'b1;
               state_in = S_DONE;
            end else if (merge_hi) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IW-1:0];
               wr_data  = {base_ff, cur_len + n_ff};
               fadd_in  = 1'b1;
               state_in = S_DONE;
            end else if (count_ff >= FULL_COUNT) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else if (pos_ff == count_ff) begin
               state_in = S_INS;
            end else begin
               rd_addr  = cnt_pv[IW-1:0];
               j_in     = cnt_pv;
               state_in = S_SHUP;
            end
         end

         S_SHDN: begin
            // move entry j down by one
            wr_en   = 1'b1;
            wr_addr = j_pv[IW-1:0];
            wr_data = rd_data;
            rd_addr = j_nx[IW-1:0];
            if (j_nx < count_ff) begin
               j_in = j_nx;
            end else begin
               state_in = S_DONE;
            end
         end

         S_SHUP: begin
            // move entry j up by one, from the tail towards pos
            wr_en   = 1'b1;
            wr_addr = j_nx[IW-1:0];
            wr_data = rd_data;
            rd_addr = j_pv[IW-1:0];
            if (j_ff == pos_ff) begin
               state_in = S_INS;
            end else begin
               j_in = j_pv;
            end
         end

         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IW-1:0];
            wr_data  = {base_ff, n_ff};
            inc_in   = 1'b1;
            fadd_in  = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (inc_ff) begin
               count_in = count_ff + 1'b1;
            end else if (dec_ff) begin
               count_in = cnt_pv;
            end
            if (fsub_ff) begin
               free_in = free_ff - n_ff;
            end else if (fadd_ff) begin
               free_in = (free_sum > {1'b0, SPACE}) ? SPACE : free_sum[LW-1:0];
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_page_in   = (status_ff == ST_OK) ? page_ff : '0;
            rsp_free_in   = free_in;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      status_ff     <= status_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      j_ff          <= j_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      hasprev_ff    <= hasprev_in;
      hascur_ff     <= hascur_in;
      inc_ff        <= inc_in;
      dec_ff        <= dec_in;
      fsub_ff       <= fsub_in;
      fadd_ff       <= fadd_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_page = rsp_page_ff;
   assign rsp_free_total = rsp_free_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("block count beyond table depth");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= SPACE)
      else $error("free total beyond page space");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("table written while idle");
`endif

endmodule

### test/first_fit_page_allocator_tb.sv
// Self-checking testbench for the first-fit page allocator: directed table, then random traffic.
module first_fit_page_allocator_tb;
   import fpa_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;
   localparam int IDX_BITS    = DEF_PAGE_INDEX_BITS;
   localparam longint SPACE   = longint'(1) << IDX_BITS;
   localparam int RANDOM_ITEMS = 1600;
   localparam int STALL_LIMIT  = 4000;  // cycles with no beat either way

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_command = '0;
   logic [IDX_BITS-1:0] req_base_page = '0;
   logic [IDX_BITS:0]   req_page_count = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [IDX_BITS-1:0] rsp_start_page;
   logic [IDX_BITS:0]   rsp_free_total;

   first_fit_page_allocator dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_base_page, .req_page_count,
      .rsp_valid, .rsp_status, .rsp_start_page, .rsp_free_total
   );

   always #2 clock = ~clock;

   typedef struct {
      status_type          status;
      logic [IDX_BITS-1:0] page;
      logic [IDX_BITS:0]   total;
   } outcome_type;

   typedef struct {
      logic [1:0]          cmd;
      logic [IDX_BITS-1:0] base;
      logic [IDX_BITS:0]   count;
      bit                  fixed;   // expected outcome typed in below
      outcome_type         want;
   } row_type;

   typedef struct {
      logic [IDX_BITS-1:0] base;
      logic [IDX_BITS:0]   count;
   } span_type;

   // shadow of the free-block table
   longint blk_base [TABLE_DEPTH];
   longint blk_len  [TABLE_DEPTH];
   int     blk_used;
   longint pages_left;

   outcome_type outcome_q[$];
   span_type    held_q[$];     // allocations not yet handed back
   bit          cur_fixed;
   outcome_type cur_want;
   int          errors, beats_in, beats_out, idle_cycles;
   int          status_seen [4];
   bit          no_gaps;

   task automatic drop_entry(input int idx);
      for (int i = idx; i + 1 < blk_used; i++) begin
         blk_base[i] = blk_base[i+1];
         blk_len[i]  = blk_len[i+1];
      end
      blk_used--;
   endtask

   // first fit: take the lowest-addressed block that is long enough
   task automatic take_pages(input longint n, output status_type st, output longint pg);
      st = ST_NO_SPACE;
      pg = 0;
      if (n <= pages_left) begin
         for (int i = 0; i < blk_used; i++) begin
            if (blk_len[i] >= n) begin
               pg = blk_base[i];
               if (blk_len[i] > n) begin
                  blk_base[i] = (blk_base[i] + n) & (SPACE - 1);
                  blk_len[i]  = blk_len[i] - n;
               end else begin
                  drop_entry(i);
               end
               pages_left -= n;
               st = ST_OK;
               break;
            end
         end
      end
   endtask

   // free and add-region share this: sorted insert with merging
   task automatic return_pages(input longint base, input longint n, output status_type st);
      int     pos;
      bit     lo, hi;
      longint last;
      pos = 0;
      st  = ST_OK;
      if (n > SPACE - base) n = SPACE - base;   // clip at the top of the space
      last = base + n;
      while (pos < blk_used && blk_base[pos] <= base) pos++;
      lo = pos > 0 && blk_base[pos-1] + blk_len[pos-1] == base;
      hi = pos < blk_used && blk_base[pos] == last;
      if (lo && hi) begin
         blk_len[pos-1] += n + blk_len[pos];
         drop_entry(pos);
      end else if (lo) begin
         blk_len[pos-1] += n;
      end else if (hi) begin
         blk_base[pos] = base;
         blk_len[pos] += n;
      end else if (blk_used >= TABLE_DEPTH) begin
         st = ST_FULL;
      end else begin
         for (int i = blk_used; i > pos; i--) begin
            blk_base[i] = blk_base[i-1];
            blk_len[i]  = blk_len[i-1];
         end
         blk_base[pos] = base;
         blk_len[pos]  = n;
         blk_used++;
      end
      if (st == ST_OK) begin
         pages_left += n;
         if (pages_left > SPACE) pages_left = SPACE;
      end
   endtask

   function automatic outcome_type dummy_outcome();
      outcome_type o;
      o.status = ST_OK;
      o.page   = '0;
      o.total  = '0;
      return o;
   endfunction

   task automatic allocator_step(input logic [1:0] cmd, input logic [IDX_BITS-1:0] base,
                                 input logic [IDX_BITS:0] cnt, output outcome_type res);
      status_type st;
      longint     pg;
      st = ST_OK;
      pg = 0;
      if (cmd != CMD_IGNORE) begin
         if (cnt == 0) st = ST_ZERO;
         else if (cmd == CMD_ALLOC) take_pages(cnt, st, pg);
         else return_pages(base, cnt, st);
      end
      if (st != ST_OK) pg = 0;
      res.status = st;
      res.page   = pg[IDX_BITS-1:0];
      res.total  = pages_left[IDX_BITS:0];
   endtask

   // request beat taken: run the shadow and queue the outcome
   always @(posedge clock) begin
      outcome_type o;
      span_type    s;
      if (!reset && start && !busy) begin
         allocator_step(req_command, req_base_page, req_page_count, o);
         if (req_command == CMD_ALLOC && o.status == ST_OK) begin
            s.base  = o.page;
            s.count = req_page_count;
            held_q.push_back(s);
         end
         outcome_q.push_back(cur_fixed ? cur_want : o);
         beats_in++;
      end
   end

   // result beat: one strobe cycle, compared with the oldest outcome
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid) begin
         beats_out++;
         status_seen[rsp_status]++;
         if (outcome_q.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
         end else begin
            w = outcome_q.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               errors++;
            end
            if (rsp_start_page !== w.page) begin
               $error("start_page: expected %0h, got %0h", w.page, rsp_start_page);
               errors++;
            end
            if (rsp_free_total !== w.total) begin
               $error("free_total: expected %0h, got %0h", w.total, rsp_free_total);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one request: optional gap, then hold start until the beat is taken
   task automatic issue(input logic [1:0] cmd, input logic [IDX_BITS-1:0] base,
                        input logic [IDX_BITS:0] cnt, input bit fixed, input outcome_type want);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_command    <= cmd;
      req_base_page  <= base;
      req_page_count <= cnt;
      cur_fixed      = fixed;
      cur_want       = want;
      do @(posedge clock); while (!(start && !busy));
   endtask

   function automatic outcome_type typed(input status_type st, input logic [IDX_BITS-1:0] pg,
                                         input logic [IDX_BITS:0] tot);
      outcome_type o;
      o.status = st;
      o.page   = pg;
      o.total  = tot;
      return o;
   endfunction

   row_type directed[$];

   task automatic add_row(input logic [1:0] cmd, input logic [IDX_BITS-1:0] base,
                          input logic [IDX_BITS:0] cnt, input bit fixed, input outcome_type want);
      row_type r;
      r.cmd = cmd; r.base = base; r.count = cnt; r.fixed = fixed; r.want = want;
      directed.push_back(r);
   endtask

   initial begin
      outcome_type         none;
      int                  pick, k;
      span_type            s;
      logic [1:0]          cmd;
      logic [IDX_BITS-1:0] base;
      logic [IDX_BITS:0]   cnt;

      none = dummy_outcome();
      blk_used = 0; pages_left = 0; errors = 0;
      beats_in = 0; beats_out = 0; idle_cycles = 0; no_gaps = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      // allocate from an empty table, zero count, unknown command
      add_row(CMD_ALLOC, 20'd0, 21'd5, 1, typed(ST_NO_SPACE, 20'd0, 21'd0));
      add_row(CMD_FREE,  20'd5, 21'd0, 1, typed(ST_ZERO, 20'd0, 21'd0));
      add_row(CMD_IGNORE, 20'hFFFFF, 21'h1FFFFF, 1, typed(ST_OK, 20'd0, 21'd0));
      // region past the top of the space is cut to a single page
      add_row(CMD_ADD, 20'hFFFFF, 21'h100000, 1, typed(ST_OK, 20'd0, 21'd1));
      // exact fit empties the table
      add_row(CMD_ALLOC, 20'h12345, 21'd1, 1, typed(ST_OK, 20'hFFFFF, 21'd0));
      add_row(CMD_ADD, 20'd0, 21'd16, 1, typed(ST_OK, 20'd0, 21'd16));
      add_row(CMD_ADD, 20'd32, 21'd16, 0, none);
      add_row(CMD_ADD, 20'd16, 21'd16, 0, none);    // merges both sides
      add_row(CMD_ALLOC, 20'd0, 21'd0, 1, typed(ST_ZERO, 20'd0, 21'd48));
      add_row(CMD_ALLOC, 20'd0, 21'd49, 1, typed(ST_NO_SPACE, 20'd0, 21'd48));
      add_row(CMD_ALLOC, 20'hFFFFF, 21'd10, 1, typed(ST_OK, 20'd0, 21'd38));
      add_row(CMD_FREE, 20'd0, 21'd10, 0, none);    // merges upward
      add_row(CMD_ADD, 20'd100, 21'd8, 0, none);
      add_row(CMD_ALLOC, 20'd0, 21'd50, 1, typed(ST_NO_SPACE, 20'd0, 21'd56));
      add_row(CMD_FREE, 20'd108, 21'd4, 0, none);   // merges downward
      add_row(CMD_FREE, 20'd40, 21'd3, 0, none);    // overlapping free
      add_row(CMD_ADD, 20'd0, 21'h100000, 1, typed(ST_OK, 20'd0, 21'h100000));
      add_row(CMD_ALLOC, 20'd0, 21'h100000, 0, none);
      add_row(CMD_ALLOC, 20'd0, 21'd7, 0, none);
      add_row(CMD_IGNORE, 20'd0, 21'd0, 0, none);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         issue(directed[i].cmd, directed[i].base, directed[i].count,
               directed[i].fixed, directed[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) no_gaps = $urandom_range(0, 2) == 0;
         // every so often fill the table with isolated single pages
         if (n == 500 || n == 1200) begin
            for (k = 0; k < TABLE_DEPTH + 6; k++)
               issue(CMD_ADD, 20'h80000 + 20'(2 * k), 21'd1, 0, none);
            issue(CMD_FREE, 20'h70000, 21'd3, 0, none);    // table full
            for (k = 0; k < TABLE_DEPTH; k++)
               issue(CMD_ALLOC, 20'd0, 21'd1, 0, none);
         end
         pick = $urandom_range(0, 99);
         cmd  = CMD_ALLOC;
         base = '0;
         cnt  = 21'($urandom_range(1, 32));
         if (pick < 42) begin
            if ($urandom_range(0, 9) == 0) cnt = 21'($urandom_range(1, 2000));
         end else if (pick < 78 && held_q.size() > 0) begin
            k = $urandom_range(0, held_q.size() - 1);
            s = held_q[k];
            held_q.delete(k);
            cmd = CMD_FREE;
            base = s.base;
            cnt = s.count;
         end else if (pick < 90) begin
            cmd  = $urandom_range(0, 1) ? CMD_ADD : CMD_FREE;
            base = 20'($urandom_range(0, 4095));
            cnt  = 21'($urandom_range(1, 64));
         end else if (pick < 96) begin
            cmd  = 2'($urandom_range(0, 3));
            base = 20'($urandom);
            cnt  = 21'($urandom);
         end else begin
            cmd  = 2'($urandom_range(0, 3));
            base = 20'($urandom);
            cnt  = '0;
         end
         issue(cmd, base, cnt, 0, none);
      end

      @(negedge clock);
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (2 * TABLE_DEPTH + 8) @(posedge clock);

      $display("%0d requests, %0d results: ok %0d, no space %0d, full %0d, zero %0d",
               beats_in, beats_out, status_seen[ST_OK], status_seen[ST_NO_SPACE],
               status_seen[ST_FULL], status_seen[ST_ZERO]);
      $display("table-full fills, saturation of the free total and merges exercised");
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_ram.sv
hw/rtl/first_fit_page_allocator.sv
test/first_fit_page_allocator_tb.sv
